// ===== rtl/lsu_pkg.sv =====
`timescale 1ns / 1ps
package lsu_pkg;

  // Memory access codes on the result channel.
  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } lsu_acc_t;

  // Input item kinds.
  localparam logic KIND_OPCODE = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  // Opcode groups found by the front end.
  typedef enum logic [4:0] {
    CLS_ILLEGAL,
    CLS_LD_R_R,
    CLS_LD_R_N,
    CLS_LD_RR_NN,
    CLS_POP,
    CLS_PUSH,
    CLS_ST_A_RR,
    CLS_LD_A_RR,
    CLS_ST_A_HLI,
    CLS_LD_A_HLI,
    CLS_LD_NN_SP,
    CLS_LD_HL_SPE,
    CLS_LD_SP_HL,
    CLS_LDH_N_A,
    CLS_LDH_A_N,
    CLS_LDH_C_A,
    CLS_LDH_A_C,
    CLS_LD_NN_A,
    CLS_LD_A_NN
  } lsu_cls_t;

  // One item as it waits in the queue.
  typedef struct packed {
    logic        kind;
    logic [7:0]  opcode;
    logic [7:0]  read_data;
    logic [15:0] pc_in;
    lsu_cls_t    cls;
  } lsu_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  access;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        done_res;
    logic [2:0]  mcycles;
    logic        illegal;
    logic [15:0] next_pc;
    logic        last;
  } lsu_res_t;

  // Builds a result with the unused fields forced to zero.
  function automatic lsu_res_t mk_res(lsu_acc_t acc, logic [15:0] addr, logic [7:0] wd,
                                      logic done, logic [2:0] mc, logic ill,
                                      logic [15:0] npc);
    lsu_res_t r;
    r.access     = acc;
    r.address    = (acc != ACC_NONE) ? addr : 16'd0;
    r.write_data = (acc == ACC_WRITE) ? wd : 8'd0;
    r.done_res   = done;
    r.mcycles    = done ? mc : 3'd0;
    r.illegal    = ill;
    r.next_pc    = done ? npc : 16'd0;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/lsu_in_if.sv =====
`timescale 1ns / 1ps
interface lsu_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  opcode;
  logic [7:0]  read_data;
  logic [15:0] pc_in;

  modport source (output valid, kind, opcode, read_data, pc_in, input ready);
  modport sink   (input valid, kind, opcode, read_data, pc_in, output ready);
endinterface

// ===== rtl/lsu_out_if.sv =====
`timescale 1ns / 1ps
interface lsu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  access;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        done_res;
  logic [2:0]  mcycles;
  logic        illegal;
  logic [15:0] next_pc;
  logic        last;

  modport source (output valid, access, address, write_data, done_res, mcycles,
                  illegal, next_pc, last, input ready);
  modport sink   (input valid, access, address, write_data, done_res, mcycles,
                  illegal, next_pc, last, output ready);
endinterface

// ===== rtl/lsu_front.sv =====
`timescale 1ns / 1ps
module lsu_front import lsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lsu_in_if.sink     in_ch,
  output logic       q_valid,
  output lsu_item_t  q_item,
  input  logic       q_pop
);

  lsu_item_t  ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push;
  lsu_item_t  new_item;

  // Sorts an opcode into its load/store group.
  function automatic lsu_cls_t classify(logic [7:0] op);
    lsu_cls_t c;
    c = CLS_ILLEGAL;
    if (op[7:6] == 2'b01 && op != 8'h76) c = CLS_LD_R_R;
    else if (op[7:6] == 2'b00 && op[2:0] == 3'b110) c = CLS_LD_R_N;
    else if ((op & 8'hCF) == 8'h01) c = CLS_LD_RR_NN;
    else if ((op & 8'hCF) == 8'hC1) c = CLS_POP;
    else if ((op & 8'hCF) == 8'hC5) c = CLS_PUSH;
    else begin
      unique case (op)
        8'h02, 8'h12: c = CLS_ST_A_RR;
        8'h0A, 8'h1A: c = CLS_LD_A_RR;
        8'h22, 8'h32: c = CLS_ST_A_HLI;
        8'h2A, 8'h3A: c = CLS_LD_A_HLI;
        8'h08:        c = CLS_LD_NN_SP;
        8'hF8:        c = CLS_LD_HL_SPE;
        8'hF9:        c = CLS_LD_SP_HL;
        8'hE0:        c = CLS_LDH_N_A;
        8'hF0:        c = CLS_LDH_A_N;
        8'hE2:        c = CLS_LDH_C_A;
        8'hF2:        c = CLS_LDH_A_C;
        8'hEA:        c = CLS_LD_NN_A;
        8'hFA:        c = CLS_LD_A_NN;
        default:      c = CLS_ILLEGAL;
      endcase
    end
    return c;
  endfunction

  // Accept while the two-entry queue has room.
  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = ent_r[rd_r];

  always_comb begin
    new_item.kind      = in_ch.kind;
    new_item.opcode    = in_ch.opcode;
    new_item.read_data = in_ch.read_data;
    new_item.pc_in     = in_ch.pc_in;
    new_item.cls       = classify(in_ch.opcode);
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  // Queue pointers and storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        ent_r[wr_r] <= new_item;
        wr_r        <= ~wr_r;
      end
      if (q_pop) rd_r <= ~rd_r;
    end
  end

endmodule

// ===== rtl/lsu_back.sv =====
`timescale 1ns / 1ps
module lsu_back import lsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  lsu_item_t  q_item,
  output logic       q_pop,
  lsu_out_if.source  out_ch
);

  logic [7:0]  rf_r [7];
  logic [7:0]  rf_nxt [7];
  logic [3:0]  flag_r, flag_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic [15:0] pc_r, pc_nxt;
  lsu_cls_t    cls_r, cls_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        out_v_r, pend_r;
  lsu_res_t    out_r, pend_res_r;
  lsu_res_t    r0, r1;
  logic [1:0]  nres;

  // Maps a 3-bit register code to the register file slot.
  function automatic logic [2:0] ri(logic [2:0] code);
    return (code == 3'd7) ? 3'd6 : code;
  endfunction

  // Take an item when no second result is pending and the output can move.
  assign q_pop = q_valid && !pend_r && (!out_v_r || out_ch.ready);

  // Executes one item against the architectural state.
  always_comb begin
    logic [7:0]  d, fl8;
    logic [2:0]  p, dc, sc;
    logic [1:0]  sel;
    logic [7:0]  op;
    lsu_cls_t    cls;
    logic [15:0] hl, w, bc, de, off, hl_step, sum16;
    logic [8:0]  sum8;
    logic [4:0]  sum4;
    logic        run;
    lsu_res_t    fin;

    for (int i = 0; i < 7; i++) rf_nxt[i] = rf_r[i];
    flag_nxt  = flag_r;
    sp_nxt    = sp_r;
    pc_nxt    = pc_r;
    cls_nxt   = cls_r;
    op_nxt    = op_r;
    phase_nxt = phase_r;
    low_nxt   = low_r;
    r0   = '0;
    r1   = '0;
    nres = 2'd0;
    run  = 1'b0;
    fin  = '0;

    if (q_item.kind == KIND_OPCODE) begin
      d       = 8'd0;
      p       = 3'd1;
      op      = q_item.opcode;
      cls     = q_item.cls;
      pc_nxt  = q_item.pc_in;
      cls_nxt = q_item.cls;
      op_nxt  = q_item.opcode;
      run     = 1'b1;
    end else begin
      d   = q_item.read_data;
      p   = phase_r;
      op  = op_r;
      cls = cls_r;
      run = (phase_r != 3'd0);
    end

    dc      = op[5:3];
    sc      = op[2:0];
    sel     = op[5:4];
    hl      = {rf_r[4], rf_r[5]};
    bc      = {rf_r[0], rf_r[1]};
    de      = {rf_r[2], rf_r[3]};
    w       = {d, low_r};
    hl_step = op[4] ? (hl - 16'd1) : (hl + 16'd1);
    off     = {{8{d[7]}}, d};
    sum16   = sp_r + off;
    sum8    = {1'b0, sp_r[7:0]} + {1'b0, d};
    sum4    = {1'b0, sp_r[3:0]} + {1'b0, d[3:0]};
    fl8     = {flag_r, 4'd0};

    if (run) begin
      // A read request advances the phase; a finish returns to idle.
      unique case (cls)
        CLS_LD_R_R: begin
          if (dc == 3'd6) begin
            r0 = mk_res(ACC_WRITE, hl, rf_r[ri(sc)], 1'b1, 3'd2, 1'b0, pc_nxt);
            nres = 2'd1; phase_nxt = 3'd0;
          end else if (sc == 3'd6 && p == 3'd1) begin
            r0 = mk_res(ACC_READ, hl, 8'd0, 1'b0, 3'd0, 1'b0, 16'd0);
            nres = 2'd1; phase_nxt = p + 3'd1;
          end else begin
            rf_nxt[ri(dc)] = (sc == 3'd6) ? d : rf_r[ri(sc)];
            r0 = mk_res(ACC_NONE, 16'd0, 8'd0, 1'b1, (sc == 3'd6) ? 3'd2 : 3'd1, 1'b0,
                        pc_nxt);
            nres = 2'd1; phase_nxt = 3'd0;
          end
        end
        CLS_LD_R_N, CLS_LD_RR_NN, CLS_LDH_N_A, CLS_LDH_A_N, CLS_LD_NN_A,
        CLS_LD_A_NN, CLS_LD_NN_SP, CLS_LD_HL_SPE: begin
          nres = 2'd1;
          if (p == 3'd1 || (p == 3'd2 && (cls == CLS_LD_RR_NN || cls == CLS_LD_NN_A ||
              cls == CLS_LD_A_NN || cls == CLS_LD_NN_SP))) begin
            // Immediate byte fetch.
            if (p == 3'd2) low_nxt = d;
            r0 = mk_res(ACC_READ, pc_r, 8'd0, 1'b0, 3'd0, 1'b0, 16'd0);
            pc_nxt = pc_r + 16'd1;
            if (p == 3'd1) begin
              r0 = mk_res(ACC_READ, q_item.kind ? pc_r : q_item.pc_in, 8'd0, 1'b0, 3'd0,
                          1'b0, 16'd0);
              pc_nxt = (q_item.kind ? pc_r : q_item.pc_in) + 16'd1;
            end
            phase_nxt = p + 3'd1;
          end else begin
            phase_nxt = 3'd0;
            unique case (cls)
              CLS_LD_R_N: begin
                if (dc == 3'd6) begin
                  r0 = mk_res(ACC_WRITE, hl, d, 1'b1, 3'd3, 1'b0, pc_r);
                end else begin
                  rf_nxt[ri(dc)] = d;
                  r0 = mk_res(ACC_NONE, 16'd0, 8'd0, 1'b1, 3'd2, 1'b0, pc_r);
                end
              end
              CLS_LD_RR_NN: begin
                if (sel == 2'd3) sp_nxt = w;
                else begin
                  rf_nxt[{sel, 1'b0}] = w[15:8];
                  rf_nxt[{sel, 1'b1}] = w[7:0];
                end
                r0 = mk_res(ACC_NONE, 16'd0, 8'd0, 1'b1, 3'd3, 1'b0, pc_r);
              end
              CLS_LDH_N_A:
                r0 = mk_res(ACC_WRITE, HIGH_PAGE | {8'd0, d}, rf_r[6], 1'b1, 3'd3, 1'b0,
                            pc_r);
              CLS_LDH_A_N: begin
                if (p == 3'd2) begin
                  r0 = mk_res(ACC_READ, HIGH_PAGE | {8'd0, d}, 8'd0, 1'b0, 3'd0, 1'b0,
                              16'd0);
                  phase_nxt = p + 3'd1;
                end else begin
                  rf_nxt[6] = d;
                  r0 = mk_res(ACC_NONE, 16'd0, 8'd0, 1'b1, 3'd3, 1'b0, pc_r);
                end
              end
              CLS_LD_NN_A:
                r0 = mk_res(ACC_WRITE, w, rf_r[6], 1'b1, 3'd4, 1'b0, pc_r);
              CLS_LD_A_NN: begin
                if (p == 3'd3) begin
                  r0 = mk_res(ACC_READ, w, 8'd0, 1'b0, 3'd0, 1'b0, 16'd0);
                  phase_nxt = p + 3'd1;
                end else begin
                  rf_nxt[6] = d;
                  r0 = mk_res(ACC_NONE, 16'd0, 8'd0, 1'b1, 3'd4, 1'b0, pc_r);
                end
              end
              CLS_LD_NN_SP: begin
                r0 = mk_res(ACC_WRITE, w, sp_r[7:0], 1'b0, 3'd0, 1'b0, 16'd0);
                r1 = mk_res(ACC_WRITE, w + 16'd1, sp_r[15:8], 1'b1, 3'd5, 1'b0, pc_r);
                nres = 2'd2;
              end
              default: begin
                // Add of SP and a signed offset into HL.
                flag_nxt = {2'b00, sum4[4], sum8[8]};
                rf_nxt[4] = sum16[15:8];
                rf_nxt[5] = sum16[7:0];
                r0 = mk_res(ACC_NONE, 16'd0, 8'd0, 1'b1, 3'd3, 1'b0, pc_r);
              end
            endcase
          end
        end
        CLS_POP: begin
          nres = 2'd1;
          if (p == 3'd1) begin
            r0 = mk_res(ACC_READ, sp_r, 8'd0, 1'b0, 3'd0, 1'b0, 16'd0);
            phase_nxt = p + 3'd1;
          end else if (p == 3'd2) begin
            low_nxt = d;
            r0 = mk_res(ACC_READ, sp_r + 16'd1, 8'd0, 1'b0, 3'd0, 1'b0, 16'd0);
            phase_nxt = p + 3'd1;
          end else begin
            if (sel == 2'd3) begin
              flag_nxt  = low_r[7:4];
              rf_nxt[6] = d;
            end else begin
              rf_nxt[{sel, 1'b0}] = d;
              rf_nxt[{sel, 1'b1}] = low_r;
            end
            sp_nxt = sp_r + 16'd2;
            r0 = mk_res(ACC_NONE, 16'd0, 8'd0, 1'b1, 3'd3, 1'b0, pc_nxt);
            phase_nxt = 3'd0;
          end
        end
        CLS_PUSH: begin
          // High byte first, then the low byte completes.
          if (sel == 2'd3) begin
            r0 = mk_res(ACC_WRITE, sp_r - 16'd1, rf_r[6], 1'b0, 3'd0, 1'b0, 16'd0);
            r1 = mk_res(ACC_WRITE, sp_r - 16'd2, fl8, 1'b1, 3'd4, 1'b0, pc_nxt);
          end else begin
            r0 = mk_res(ACC_WRITE, sp_r - 16'd1, rf_r[{sel, 1'b0}], 1'b0, 3'd0, 1'b0,
                        16'd0);
            r1 = mk_res(ACC_WRITE, sp_r - 16'd2, rf_r[{sel, 1'b1}], 1'b1, 3'd4, 1'b0,
                        pc_nxt);
          end
          sp_nxt = sp_r - 16'd2;
          nres = 2'd2; phase_nxt = 3'd0;
        end
        CLS_ST_A_RR: begin
          r0 = mk_res(ACC_WRITE, op[4] ? de : bc, rf_r[6], 1'b1, 3'd2, 1'b0, pc_nxt);
          nres = 2'd1; phase_nxt = 3'd0;
        end
        CLS_ST_A_HLI: begin
          rf_nxt[4] = hl_step[15:8];
          rf_nxt[5] = hl_step[7:0];
          r0 = mk_res(ACC_WRITE, hl, rf_r[6], 1'b1, 3'd2, 1'b0, pc_nxt);
          nres = 2'd1; phase_nxt = 3'd0;
        end
        CLS_LD_A_RR, CLS_LD_A_HLI, CLS_LDH_A_C: begin
          nres = 2'd1;
          if (p == 3'd1) begin
            fin.address = (cls == CLS_LD_A_RR) ? (op[4] ? de : bc) :
                          (cls == CLS_LD_A_HLI) ? hl : (HIGH_PAGE | {8'd0, rf_r[1]});
            r0 = mk_res(ACC_READ, fin.address, 8'd0, 1'b0, 3'd0, 1'b0, 16'd0);
            phase_nxt = p + 3'd1;
          end else begin
            rf_nxt[6] = d;
            if (cls == CLS_LD_A_HLI) begin
              rf_nxt[4] = hl_step[15:8];
              rf_nxt[5] = hl_step[7:0];
            end
            r0 = mk_res(ACC_NONE, 16'd0, 8'd0, 1'b1, 3'd2, 1'b0, pc_nxt);
            phase_nxt = 3'd0;
          end
        end
        CLS_LD_SP_HL: begin
          sp_nxt = hl;
          r0 = mk_res(ACC_NONE, 16'd0, 8'd0, 1'b1, 3'd2, 1'b0, pc_nxt);
          nres = 2'd1; phase_nxt = 3'd0;
        end
        CLS_LDH_C_A: begin
          r0 = mk_res(ACC_WRITE, HIGH_PAGE | {8'd0, rf_r[1]}, rf_r[6], 1'b1, 3'd2, 1'b0,
                      pc_nxt);
          nres = 2'd1; phase_nxt = 3'd0;
        end
        default: begin
          r0 = mk_res(ACC_NONE, 16'd0, 8'd0, 1'b1, 3'd0, 1'b1, pc_nxt);
          nres = 2'd1; phase_nxt = 3'd0;
        end
      endcase
    end
    r0.last = (nres == 2'd1);
    r1.last = 1'b1;
  end

  // State update and output register with one pending second result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) rf_r[i] <= 8'd0;
      flag_r  <= 4'd0;
      sp_r    <= 16'd0;
      pc_r    <= 16'd0;
      cls_r   <= CLS_ILLEGAL;
      op_r    <= 8'd0;
      phase_r <= 3'd0;
      low_r   <= 8'd0;
      out_v_r <= 1'b0;
      pend_r  <= 1'b0;
    end else if (q_pop) begin
      for (int i = 0; i < 7; i++) rf_r[i] <= rf_nxt[i];
      flag_r  <= flag_nxt;
      sp_r    <= sp_nxt;
      pc_r    <= pc_nxt;
      cls_r   <= cls_nxt;
      op_r    <= op_nxt;
      phase_r <= phase_nxt;
      low_r   <= low_nxt;
      out_v_r <= (nres != 2'd0);
      out_r   <= r0;
      pend_r  <= (nres == 2'd2);
      pend_res_r <= r1;
    end else if (out_v_r && out_ch.ready) begin
      out_v_r <= pend_r;
      out_r   <= pend_res_r;
      pend_r  <= 1'b0;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.access     = out_r.access;
  assign out_ch.address    = out_r.address;
  assign out_ch.write_data = out_r.write_data;
  assign out_ch.done_res   = out_r.done_res;
  assign out_ch.mcycles    = out_r.mcycles;
  assign out_ch.illegal    = out_r.illegal;
  assign out_ch.next_pc    = out_r.next_pc;
  assign out_ch.last       = out_r.last;

`ifndef SYNTHESIS
  a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_v_r) else $error("pending result without a shown result");
  a_pend_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !q_pop) else $error("item taken while a second result waits");
  a_pend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (pend_res_r.last && pend_res_r.done_res))
    else $error("second result must complete the instruction");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && nres != 2'd0 && (nres == 2'd2 || r0.done_res)) |=> (phase_r == 3'd0))
    else $error("phase not idle after a completed instruction");
`endif

endmodule

// ===== rtl/cpu_load_store_unit.sv =====
`timescale 1ns / 1ps
// An accepted item is registered in the queue, then executed and its result registered in the output register.
// Throughput: one item per cycle while the output is not stalled; PUSH and LD (nn),SP hold the
// executor while their second result waits to go out through the single output register.
// The two-entry queue between decode and execute absorbs output stalls.
// Reset (rst_n low, synchronous) clears registers, flags, SP, PC, phase, queue and output.
module cpu_load_store_unit import lsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lsu_in_if.sink    in_ch,
  lsu_out_if.source out_ch
);

  logic      q_valid;
  logic      q_pop;
  lsu_item_t q_item;

  lsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  lsu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
